[hw/rtl/c8cfe_pkg.sv]
// -----------------------------------------------------------------------------
// c8cfe_pkg
// Shared widths, opcode groups and constants of the control-flow execute block.
// -----------------------------------------------------------------------------
package c8cfe_pkg;

   localparam int unsigned WORD_W   = 16;
   localparam int unsigned RAND_W   = 8;
   localparam int unsigned PC_W     = 13;
   localparam int unsigned INDEX_W  = 12;
   localparam int unsigned REG_W    = 8;
   localparam int unsigned REG_NUM_W = 4;
   localparam int unsigned NUM_REGS = 16;

   localparam int unsigned REQ_DATA_W = 24;   // word + random byte
   localparam int unsigned RSP_DATA_W = 40;   // 39 field bits, padded to bytes

   localparam int unsigned STACK_DEPTH_DEFAULT = 16;

   localparam logic [PC_W-1:0] START_ADDRESS = 13'h0200;
   localparam logic [PC_W-1:0] PC_LIMIT      = 13'h1000;
   localparam logic [PC_W-1:0] PC_CLAMP      = 13'h0FFF;
   localparam logic [PC_W-1:0] PC_STEP       = 13'h0002;

   // Instruction groups (top nibble)
   localparam logic [3:0] OP_SYS      = 4'h0;
   localparam logic [3:0] OP_JUMP     = 4'h1;
   localparam logic [3:0] OP_CALL     = 4'h2;
   localparam logic [3:0] OP_SEQ_IMM  = 4'h3;
   localparam logic [3:0] OP_SNE_IMM  = 4'h4;
   localparam logic [3:0] OP_SEQ_REG  = 4'h5;
   localparam logic [3:0] OP_LOAD_IMM = 4'h6;
   localparam logic [3:0] OP_ADD_IMM  = 4'h7;
   localparam logic [3:0] OP_SNE_REG  = 4'h9;
   localparam logic [3:0] OP_SET_IDX  = 4'hA;
   localparam logic [3:0] OP_JUMP_V0  = 4'hB;
   localparam logic [3:0] OP_RAND     = 4'hC;

   // System group sub-codes (low nibble)
   localparam logic [3:0] SYS_CLS = 4'h0;
   localparam logic [3:0] SYS_RET = 4'hE;

endpackage

[hw/rtl/chip8_control_flow_execute.sv]
// -----------------------------------------------------------------------------
// chip8_control_flow_execute
// Executes one fetched instruction per transaction and reports the next fetch
// address, the index register, a clear-screen strobe and any register write.
//  - req channel: one transaction per fetched instruction, tdata carries the
//    instruction word and a fresh random byte.
//  - rsp channel: one transaction per instruction with the resulting state.
//  - Timing: a request is captured in the operand register on acceptance and its
//    result in the result register. Throughput: one instruction per cycle while
//    rsp_tready holds; the program counter, stack pointer and register file update as an instruction runs.
//  - Register operands Vx and Vy are read from the register file when the
//    request is taken, with a bypass from the instruction executing then.
//  - The top of the return stack is held in a register, refilled from the
//    stack memory on a return, so a return takes its target from that register.
//  - Reset: program counter to 0x200, registers, index and stack pointer to
//    zero; stack contents stay undefined until a call writes them.
//  - When rsp_tready is low the result register holds, execution stops and
//    req_tready drops once the operand register is full.
// -----------------------------------------------------------------------------
module chip8_control_flow_execute #(
   parameter int unsigned STACK_DEPTH = c8cfe_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] instruction_word, [23:16] random_value
   input  logic [c8cfe_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [12:0] fetch_address, [24:13] index_value, [25] clear_screen,
   // [26] reg_written, [30:27] reg_number, [38:31] reg_data, [39] zero
   output logic [c8cfe_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import c8cfe_pkg::*;

   localparam int unsigned SP_W = $clog2(STACK_DEPTH);
   localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

   // Operand register
   logic                  in_valid_ff;
   logic [WORD_W-1:0]     word_ff;
   logic [RAND_W-1:0]     rand_ff;
   logic [REG_W-1:0]      vx_ff;
   logic [REG_W-1:0]      vy_ff;

   // Architectural state
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   logic [SP_W-1:0]       sp_ff, sp_in;
   logic [REG_W-1:0]      v0_ff;
   logic [NUM_REGS-1:0]   reg_valid_ff;
   logic [REG_W-1:0]      reg_mem [NUM_REGS];
   logic [PC_W-1:0]       stack_mem [STACK_DEPTH];
   logic [PC_W-1:0]       top_ff;

   // Result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  fire;
   logic                  req_take;
   logic [3:0]            group;
   logic [REG_NUM_W-1:0]  x_num;
   logic [3:0]            low_nib;
   logic [REG_W-1:0]      nn;
   logic [INDEX_W-1:0]    nnn;
   logic [PC_W-1:0]       pc_adv;
   logic [PC_W-1:0]       pc_skip;
   logic                  is_call;
   logic                  is_ret;
   logic                  cls;
   logic                  wr;
   logic [REG_W-1:0]      wdata;
   logic [SP_W-1:0]       sp_inc;
   logic [SP_W-1:0]       sp_dec;
   logic [SP_W-1:0]       sp_dec2;
   logic [REG_NUM_W-1:0]  req_x;
   logic [REG_NUM_W-1:0]  req_y;
   logic                  fwd_x;
   logic                  fwd_y;

   assign fire       = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | fire;
   assign req_take   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign group   = word_ff[15:12];
   assign x_num   = word_ff[11:8];
   assign low_nib = word_ff[3:0];
   assign nn      = word_ff[7:0];
   assign nnn     = word_ff[11:0];

   assign sp_inc  = (sp_ff == SP_LAST) ? '0 : sp_ff + SP_W'(1);
   assign sp_dec  = (sp_ff == '0) ? SP_LAST : sp_ff - SP_W'(1);
   assign sp_dec2 = (sp_dec == '0) ? SP_LAST : sp_dec - SP_W'(1);

   assign pc_adv  = (pc_ff < PC_LIMIT) ? pc_ff + PC_STEP : PC_CLAMP;
   assign pc_skip = pc_adv + PC_STEP;

   always_comb begin
      pc_in    = pc_adv;
      index_in = index_ff;
      sp_in    = sp_ff;
      is_call  = 1'b0;
      is_ret   = 1'b0;
      cls      = 1'b0;
      wr       = 1'b0;
      wdata    = '0;
      case (group)
         OP_SYS: begin
            if (low_nib == SYS_CLS) begin
               cls = 1'b1;
            end else if (low_nib == SYS_RET) begin
               is_ret = 1'b1;
               sp_in  = sp_dec;
               pc_in  = top_ff;
            end
         end
         OP_JUMP: begin
            pc_in = {1'b0, nnn};
         end
         OP_CALL: begin
            is_call = 1'b1;
            sp_in   = sp_inc;
            pc_in   = {1'b0, nnn};
         end
         OP_SEQ_IMM: begin
            if (vx_ff == nn) pc_in = pc_skip;
         end
         OP_SNE_IMM: begin
            if (vx_ff != nn) pc_in = pc_skip;
         end
         OP_SEQ_REG: begin
            if (vx_ff == vy_ff) pc_in = pc_skip;
         end
         OP_LOAD_IMM: begin
            wr    = 1'b1;
            wdata = nn;
         end
         OP_ADD_IMM: begin
            wr    = 1'b1;
            wdata = vx_ff + nn;
         end
         OP_SNE_REG: begin
            if (vx_ff != vy_ff) pc_in = pc_skip;
         end
         OP_SET_IDX: begin
            index_in = nnn;
         end
         OP_JUMP_V0: begin
            pc_in = {1'b0, nnn} + {{(PC_W-REG_W){1'b0}}, v0_ff};
         end
         OP_RAND: begin
            wr    = 1'b1;
            wdata = rand_ff & nn;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in = {1'b0,
                     wdata,
                     wr ? x_num : {REG_NUM_W{1'b0}},
                     wr,
                     cls,
                     index_in,
                     pc_in};
   end

   // Operand read with bypass from the instruction executing this cycle
   assign req_x = req_tdata[11:8];
   assign req_y = req_tdata[7:4];
   assign fwd_x = fire & wr & (x_num == req_x);
   assign fwd_y = fire & wr & (x_num == req_y);

   always_ff @(posedge clock) begin
      if (req_take) begin
         word_ff <= req_tdata[WORD_W-1:0];
         rand_ff <= req_tdata[WORD_W+RAND_W-1:WORD_W];
         vx_ff   <= fwd_x ? wdata : (reg_valid_ff[req_x] ? reg_mem[req_x] : '0);
         vy_ff   <= fwd_y ? wdata : (reg_valid_ff[req_y] ? reg_mem[req_y] : '0);
      end
   end

   // Register file and return stack storage
   always_ff @(posedge clock) begin
      if (fire && wr) begin
         reg_mem[x_num] <= wdata;
      end
      if (fire && is_call) begin
         stack_mem[sp_ff] <= pc_adv;
      end
      if (fire && is_call) begin
         top_ff <= pc_adv;
      end else if (fire && is_ret) begin
         top_ff <= stack_mem[sp_dec2];
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= START_ADDRESS;
         index_ff     <= '0;
         sp_ff        <= '0;
         v0_ff        <= '0;
         reg_valid_ff <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fire) begin
            pc_ff    <= pc_in;
            index_ff <= index_in;
            sp_ff    <= sp_in;
            if (wr) begin
               reg_valid_ff[x_num] <= 1'b1;
               if (x_num == '0) v0_ff <= wdata;
            end
         end
      end
   end

endmodule
